@@ rtl/agob_pkg.sv @@
// Shared types, constants and divide-by-255 helpers for the ARGB glyph and over blend unit.
package agob_pkg;

  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
  localparam int unsigned QBITS      = 8;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = QBITS / DIV_BITS;

  localparam logic [7:0]  BYTE_MAX = 8'hFF;
  localparam logic [7:0]  BYTE_MIN = 8'h00;
  localparam logic [15:0] RCP16    = 16'h8081;
  localparam logic [23:0] RCP24    = 24'h80_8081;

  localparam logic [0:0] CFG_FRONT = 1'b0;
  localparam logic [0:0] CFG_BACK  = 1'b1;

  typedef enum logic {
    REQ_GLYPH = 1'b0,
    REQ_OVER  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    CLS_KEEP,
    CLS_FRONT,
    CLS_MIX,
    CLS_OVER
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [7:0]  cov;
    logic [31:0] src;
    logic [31:0] dst;
  } item_t;

  typedef struct packed {
    cls_e            cls;
    logic [31:0]     pix;
    logic [7:0]      oa;
    logic [2:0][16:0] rem;
    logic [2:0][7:0] quo;
    logic [2:0]      ovf;
  } divw_t;

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RCP16);
    return p[30:23];
  endfunction

  // Exact floor(x / 255) for x up to 255 * 255 * 255.
  function automatic logic [15:0] div255_24(input logic [23:0] x);
    logic [47:0] p;
    p = 48'(x) * 48'(RCP24);
    return p[46:31];
  endfunction

endpackage

@@ rtl/agob_front.sv @@
// Front end: input register and classification of each pixel request.
module agob_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [7:0]          coverage_i,
  input  logic [31:0]         src_pixel_i,
  input  logic [31:0]         dst_pixel_i,
  output logic                push_o,
  output agob_pkg::item_t     push_data_o,
  input  logic                full_i
);
  import agob_pkg::*;

  logic  fe_valid_q, fe_valid_d;
  item_t fe_item_q, fe_item_d;
  logic  accept;

  assign in_stall_o = fe_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = fe_valid_q && !full_i;
  assign push_data_o = fe_item_q;

  always_comb begin
    fe_item_d.cov = coverage_i;
    fe_item_d.src = src_pixel_i;
    fe_item_d.dst = dst_pixel_i;
    if (req_e'(req_type_i) == REQ_OVER) begin
      fe_item_d.cls = CLS_OVER;
    end else if (coverage_i == BYTE_MIN) begin
      fe_item_d.cls = CLS_KEEP;
    end else if (coverage_i == BYTE_MAX) begin
      fe_item_d.cls = CLS_FRONT;
    end else begin
      fe_item_d.cls = CLS_MIX;
    end
  end

  always_comb begin
    fe_valid_d = fe_valid_q;
    if (accept) begin
      fe_valid_d = 1'b1;
    end else if (push_o) begin
      fe_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else begin
      fe_valid_q <= fe_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fe_item_q <= fe_item_d;
    end
  end

  // A stalled input is only possible while a request is held here.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> fe_valid_q)
    else $error("input stalled with an empty front register");

endmodule

@@ rtl/agob_fifo.sv @@
// Short queue between the front end and the blend pipeline.
module agob_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  agob_pkg::item_t     data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output agob_pkg::item_t     data_o,
  output logic                full_o
);
  import agob_pkg::*;

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != QCNT_W'(QDEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");

endmodule

@@ rtl/agob_div.sv @@
// Pipelined restoring divider for the three source-over color channels.
module agob_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  agob_pkg::divw_t     data_i,
  output logic                valid_o,
  output agob_pkg::divw_t     data_o
);
  import agob_pkg::*;

  logic  valid_q [DIV_STAGES];
  divw_t stage_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    localparam int unsigned HI = QBITS - 1 - g * DIV_BITS;
    divw_t st_in;
    divw_t st_out;
    logic  v_in;

    if (g == 0) begin : g_first
      assign st_in = data_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign st_in = stage_q[g-1];
      assign v_in  = valid_q[g-1];
    end

    always_comb begin
      logic [16:0] dv;
      logic [2:0]  bidx;
      st_out = st_in;
      for (int ch = 0; ch < 3; ch++) begin
        // The quotient only has eight bits; a larger one saturates later.
        if (g == 0) begin
          st_out.ovf[ch] = st_in.rem[ch] >= (17'(st_in.oa) << QBITS);
        end
        for (int j = 0; j < DIV_BITS; j++) begin
          bidx = 3'(HI - j);
          dv   = 17'(st_in.oa) << bidx;
          if (st_out.rem[ch] >= dv) begin
            st_out.rem[ch]       = st_out.rem[ch] - dv;
            st_out.quo[ch][bidx] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[g] <= st_out;
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign data_o  = stage_q[DIV_STAGES-1];

endmodule

@@ rtl/agob_back.sv @@
// Blend pipeline: glyph mix and source-over arithmetic with the result register.
module agob_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  agob_pkg::item_t     q_data_i,
  output logic                q_pop_o,
  input  logic [31:0]         front_color_i,
  input  logic [31:0]         back_color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         out_pixel_o,
  output logic                unchanged_o
);
  import agob_pkg::*;

  typedef struct packed {
    cls_e             cls;
    logic [7:0]       cov;
    logic [31:0]      dst;
    logic [7:0]       a;
    logic [7:0]       na;
    logic [3:0][15:0] mnum;
    logic [2:0][15:0] sa;
    logic [2:0][15:0] dd;
    logic [15:0]      da255;
  } s1_t;

  typedef struct packed {
    cls_e             cls;
    logic [7:0]       cov;
    logic [31:0]      dst;
    logic [7:0]       a;
    logic [3:0][7:0]  m;
    logic [2:0][15:0] sa;
    logic [2:0][23:0] ddn;
    logic [7:0]       oafrac;
  } s2_t;

  typedef struct packed {
    cls_e             cls;
    logic [31:0]      dst;
    logic [3:0][15:0] n;
    logic [2:0][15:0] sa;
    logic [2:0][15:0] q2;
    logic [7:0]       oa;
  } s3_t;

  logic  adv;
  logic  v1_q, v2_q, v3_q, v4_q;
  s1_t   s1_q, s1_d;
  s2_t   s2_q, s2_d;
  s3_t   s3_q, s3_d;
  divw_t s4_q, s4_d;
  logic  dv_valid;
  divw_t dv_data;
  logic  out_valid_q, out_valid_d;
  logic [31:0] out_pixel_q, out_pixel_d;
  logic  unchanged_q, unchanged_d;

  // The whole pipeline moves together unless a finished result is held.
  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = q_valid_i && adv;

  always_comb begin
    logic [7:0] ncov;
    logic [7:0] da;
    ncov       = BYTE_MAX - q_data_i.cov;
    da         = q_data_i.dst[31:24];
    s1_d.cls   = q_data_i.cls;
    s1_d.cov   = q_data_i.cov;
    s1_d.dst   = q_data_i.dst;
    s1_d.a     = q_data_i.src[31:24];
    s1_d.na    = BYTE_MAX - q_data_i.src[31:24];
    for (int k = 0; k < 4; k++) begin
      s1_d.mnum[k] = 16'(q_data_i.cov) * 16'(front_color_i[8*k +: 8])
                   + 16'(ncov) * 16'(back_color_i[8*k +: 8]);
    end
    for (int k = 0; k < 3; k++) begin
      s1_d.sa[k] = 16'(q_data_i.src[8*k +: 8]) * 16'(q_data_i.src[31:24]);
      s1_d.dd[k] = 16'(q_data_i.dst[8*k +: 8]) * 16'(da);
    end
    s1_d.da255 = 16'(da) * 16'(s1_d.na);
  end

  always_comb begin
    s2_d.cls = s1_q.cls;
    s2_d.cov = s1_q.cov;
    s2_d.dst = s1_q.dst;
    s2_d.a   = s1_q.a;
    s2_d.sa  = s1_q.sa;
    for (int k = 0; k < 4; k++) begin
      s2_d.m[k] = div255_16(s1_q.mnum[k]);
    end
    for (int k = 0; k < 3; k++) begin
      s2_d.ddn[k] = 24'(s1_q.dd[k]) * 24'(s1_q.na);
    end
    s2_d.oafrac = div255_16(s1_q.da255);
  end

  always_comb begin
    logic [7:0] ncov;
    ncov     = BYTE_MAX - s2_q.cov;
    s3_d.cls = s2_q.cls;
    s3_d.dst = s2_q.dst;
    s3_d.sa  = s2_q.sa;
    for (int k = 0; k < 4; k++) begin
      s3_d.n[k] = 16'(s2_q.cov) * 16'(s2_q.m[k]) + 16'(ncov) * 16'(s2_q.dst[8*k +: 8]);
    end
    for (int k = 0; k < 3; k++) begin
      s3_d.q2[k] = div255_24(s2_q.ddn[k]);
    end
    // da * (255 - a) / 255 never exceeds 255 - a, so this sum stays a byte.
    s3_d.oa = s2_q.a + s2_q.oafrac;
  end

  always_comb begin
    logic [31:0] mixpix;
    for (int k = 0; k < 4; k++) begin
      mixpix[8*k +: 8] = div255_16(s3_q.n[k]);
    end
    s4_d.cls = s3_q.cls;
    s4_d.oa  = s3_q.oa;
    s4_d.quo = '0;
    s4_d.ovf = '0;
    for (int k = 0; k < 3; k++) begin
      s4_d.rem[k] = 17'(s3_q.sa[k]) + 17'(s3_q.q2[k]);
    end
    case (s3_q.cls)
      CLS_MIX:   s4_d.pix = mixpix;
      CLS_FRONT: s4_d.pix = front_color_i;
      default:   s4_d.pix = s3_q.dst;
    endcase
  end

  agob_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .data_i  (s4_q),
    .valid_o (dv_valid),
    .data_o  (dv_data)
  );

  always_comb begin
    logic [31:0] over_pix;
    over_pix = {dv_data.oa, 24'h0};
    for (int k = 0; k < 3; k++) begin
      over_pix[8*k +: 8] = dv_data.ovf[k] ? BYTE_MAX : dv_data.quo[k];
    end
    if (dv_data.oa == BYTE_MIN) begin
      over_pix = '0;
    end
    out_valid_d = adv ? dv_valid : out_valid_q;
    out_pixel_d = (dv_data.cls == CLS_OVER) ? over_pix : dv_data.pix;
    unchanged_d = dv_data.cls == CLS_KEEP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= q_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      s3_q        <= s3_d;
      s4_q        <= s4_d;
      out_pixel_q <= out_pixel_d;
      unchanged_q <= unchanged_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign unchanged_o = unchanged_q;

  a_result_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(dv_valid))
    else $error("result appeared without a pixel leaving the divider");

endmodule

@@ rtl/argb_glyph_and_over_blend.sv @@
// Top level of the ARGB8888 glyph coverage and source-over blend unit.
// The unit takes one pixel request per clock while in_stall_o is low and returns one pixel
// per request, in order. The front register classifies each request and hands it to a
// four-entry queue; the blend pipeline behind it has four multiply stages (products,
// reciprocal divides by 255) and a four-stage divider for the source-over color channels.
// Throughput stays at one pixel per cycle while the output is not stalled. Front and back
// colors are written through the configuration port, which is always ready, and must only
// change while the unit is idle.
module argb_glyph_and_over_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  coverage_i,
  input  logic [31:0] src_pixel_i,
  input  logic [31:0] dst_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_pixel_o,
  output logic        unchanged_o
);
  import agob_pkg::*;

  logic [31:0] front_color_q, front_color_d;
  logic [31:0] back_color_q, back_color_d;
  logic        push;
  item_t       push_data;
  logic        full;
  logic        q_valid;
  item_t       q_data;
  logic        q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    front_color_d = front_color_q;
    back_color_d  = back_color_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRONT: front_color_d = cfg_data_i;
        CFG_BACK:  back_color_d  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_color_q <= '0;
      back_color_q  <= '0;
    end else begin
      front_color_q <= front_color_d;
      back_color_q  <= back_color_d;
    end
  end

  agob_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .coverage_i  (coverage_i),
    .src_pixel_i (src_pixel_i),
    .dst_pixel_i (dst_pixel_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  agob_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .full_o  (full)
  );

  agob_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .front_color_i (front_color_q),
    .back_color_i  (back_color_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_pixel_o   (out_pixel_o),
    .unchanged_o   (unchanged_o)
  );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the ARGB glyph coverage and source-over blend unit.
`timescale 1ns / 100ps

module tb_top;
  import agob_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RAND_ITEMS  = 215;

  typedef struct {
    req_e        kind;
    logic [7:0]  cov;
    logic [31:0] src;
    logic [31:0] dst;
  } pix_req_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        unchanged;
  } pix_res_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = CFG_FRONT;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        req_type_i  = REQ_GLYPH;
  logic [7:0]  coverage_i  = '0;
  logic [31:0] src_pixel_i = '0;
  logic [31:0] dst_pixel_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_pixel_o;
  logic        unchanged_o;

  // Model copies of the two color registers.
  logic [31:0] front_copy = '0;
  logic [31:0] back_copy  = '0;

  pix_req_t    pending_reqs[$];
  pix_res_t    pixel_q[$];
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 76;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  argb_glyph_and_over_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .coverage_i  (coverage_i),
    .src_pixel_i (src_pixel_i),
    .dst_pixel_i (dst_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pixel_o (out_pixel_o),
    .unchanged_o (unchanged_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned mix255(input int unsigned c, input int unsigned x,
                                         input int unsigned y);
    return (c * x + (255 - c) * y) / 255;
  endfunction

  function automatic logic [31:0] blend_glyph(input logic [7:0] cov, input logic [31:0] dst);
    logic [31:0] res;
    int unsigned m;
    res = '0;
    if (cov == BYTE_MAX) begin
      return front_copy;
    end
    for (int sh = 0; sh < 32; sh += 8) begin
      m = mix255(32'(cov), 32'(front_copy[sh +: 8]), 32'(back_copy[sh +: 8]));
      res[sh +: 8] = 8'(mix255(32'(cov), m, 32'(dst[sh +: 8])));
    end
    return res;
  endfunction

  function automatic logic [31:0] composite_over(input logic [31:0] src, input logic [31:0] dst);
    logic [31:0] res;
    int unsigned a, da, oa, q;
    a  = 32'(src[31:24]);
    da = 32'(dst[31:24]);
    oa = a + (da * (255 - a)) / 255;
    if (oa == 0) begin
      return '0;
    end
    res = '0;
    res[31:24] = 8'(oa);
    for (int sh = 0; sh < 24; sh += 8) begin
      q = (32'(src[sh +: 8]) * a + (32'(dst[sh +: 8]) * da * (255 - a)) / 255) / oa;
      // Colors can exceed full scale when the output alpha is tiny.
      if (q > 255) begin
        q = 255;
      end
      res[sh +: 8] = 8'(q);
    end
    return res;
  endfunction

  function automatic pix_res_t predict_pixel(input req_e kind, input logic [7:0] cov,
                                             input logic [31:0] src, input logic [31:0] dst);
    pix_res_t r;
    r.unchanged = 1'b0;
    if (kind == REQ_OVER) begin
      r.pixel = composite_over(src, dst);
    end else if (cov == BYTE_MIN) begin
      r.pixel     = dst;
      r.unchanged = 1'b1;
    end else begin
      r.pixel = blend_glyph(cov, dst);
    end
    return r;
  endfunction

  function automatic pix_req_t make_req(input req_e kind, input logic [7:0] cov,
                                        input logic [31:0] src, input logic [31:0] dst);
    pix_req_t r;
    r.kind = kind;
    r.cov  = cov;
    r.src  = src;
    r.dst  = dst;
    return r;
  endfunction

  function automatic logic [7:0] rand_alpha();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return BYTE_MIN;
      1: return BYTE_MAX;
      2: return 8'($urandom_range(1, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_req_t rand_req();
    pix_req_t r;
    int unsigned sel;
    r.kind = ($urandom_range(0, 1) == 1) ? REQ_OVER : REQ_GLYPH;
    sel = $urandom_range(0, 9);
    r.cov = (sel == 0) ? BYTE_MIN : (sel == 1) ? BYTE_MAX : 8'($urandom);
    r.src = $urandom;
    r.dst = $urandom;
    r.src[31:24] = rand_alpha();
    r.dst[31:24] = rand_alpha();
    return r;
  endfunction

  // Sender: a stalled transfer keeps its payload; otherwise the next item may go out.
  always @(posedge clk_i or negedge rst_ni) begin
    pix_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        pixel_q.push_back(predict_pixel(req_e'(req_type_i), coverage_i, src_pixel_i,
                                        dst_pixel_i));
      end
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        req_type_i  <= nxt.kind;
        coverage_i  <= nxt.cov;
        src_pixel_i <= nxt.src;
        dst_pixel_i <= nxt.dst;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: check each output transfer against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    pix_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected output: pixel %h unchanged %b", out_pixel_o, unchanged_o);
          end
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_o !== want.pixel || unchanged_o !== want.unchanged) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("bad output: pixel %h (want %h) unchanged %b (want %b)",
                       out_pixel_o, want.pixel, unchanged_o, want.unchanged);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("argb_glyph_and_over_blend: mismatch");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || pixel_q.size() != 0) begin
      @(posedge clk_i);
      // Let the driver and monitor finish this edge before looking again.
      #1;
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_FRONT) begin
      front_copy = val;
    end else begin
      back_copy = val;
    end
  endtask

  task automatic set_colors(input logic [31:0] front, input logic [31:0] back);
    wait_idle();
    write_reg(CFG_FRONT, front);
    write_reg(CFG_BACK, back);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic random_phase(input logic [31:0] front, input logic [31:0] back);
    set_colors(front, back);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pending_reqs.push_back(rand_req());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_colors(32'hC03F_80FF, 32'h4010_E000);
    set_idling(27, 76);
    // Coverage extremes, the unchanged case and the front-color shortcut.
    pending_reqs.push_back(make_req(REQ_GLYPH, BYTE_MIN, 32'hFFFF_FFFF, 32'h1234_5678));
    pending_reqs.push_back(make_req(REQ_GLYPH, BYTE_MIN, 32'h0000_0000, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_GLYPH, BYTE_MAX, 32'hFFFF_FFFF, 32'h0000_0000));
    pending_reqs.push_back(make_req(REQ_GLYPH, 8'h01, 32'h0000_0000, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_GLYPH, 8'hFE, 32'hFFFF_FFFF, 32'h0000_0000));
    pending_reqs.push_back(make_req(REQ_GLYPH, 8'h80, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
    pending_reqs.push_back(make_req(REQ_GLYPH, 8'h7F, 32'h0000_0000, 32'hFFFF_FFFF));
    // Source-over: zero output alpha, opaque source, transparent source.
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MAX, 32'h0000_0000, 32'h0000_0000));
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MIN, 32'h00FF_FFFF, 32'h00FF_FFFF));
    pending_reqs.push_back(make_req(REQ_OVER, 8'h55, 32'hFFFF_FFFF, 32'h0000_0000));
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MIN, 32'hFF12_3456, 32'hFFAB_CDEF));
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MAX, 32'h00FF_FFFF, 32'hFF80_4020));
    pending_reqs.push_back(make_req(REQ_OVER, 8'h01, 32'h80FF_0080, 32'hFF00_FF7F));
    // Tiny output alpha drives the color quotients past full scale; then full output alpha.
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MIN, 32'h01FF_FFFF, 32'h01FF_FFFF));
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MIN, 32'h0180_C0FF, 32'h02FF_FFFF));
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_OVER, BYTE_MIN, 32'h0000_0000, 32'hFFFF_FFFF));

    random_phase(32'hFFFF_FFFF, 32'h0000_0000);
    random_phase($urandom, $urandom);
    wait_idle();
    set_idling(76, 27);
    random_phase(32'h0000_0000, 32'hFFFF_FFFF);
    random_phase($urandom, $urandom);
    wait_idle();
    set_idling(0, 0);
    random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase($urandom, $urandom);
    random_phase(32'h0000_0000, 32'h0000_0000);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    fail_count += pixel_q.size();
    if (fail_count == 0) begin
      $display("argb_glyph_and_over_blend: match");
    end else begin
      $display("argb_glyph_and_over_blend: mismatch");
    end
    $finish;
  end

endmodule
